// ===== src/ljfs_pkg.sv =====
// Shared types and codes for the longest-job-first select block.
// No dependencies; imported by ljfs_table, ljfs_ctrl and the top level.
package ljfs_pkg;

   localparam int PID_W  = 16;
   localparam int TIME_W = 16;

   // state of a handed-back process
   localparam logic [1:0] PSTATE_READY    = 2'd0;
   localparam logic [1:0] PSTATE_BLOCKED  = 2'd1;
   localparam logic [1:0] PSTATE_FINISHED = 2'd2;
   localparam logic [1:0] PSTATE_INVALID  = 2'd3;

   typedef enum logic [2:0] {
      ROUTE_NONE     = 3'd0,
      ROUTE_READY    = 3'd1,
      ROUTE_BLOCKED  = 3'd2,
      ROUTE_FINISHED = 3'd3,
      ROUTE_INVALID  = 3'd4
   } route_type;

   typedef struct packed {
      logic [PID_W-1:0]  pid;
      logic [TIME_W-1:0] rtime;
   } entry_type;

   typedef struct packed {
      logic              sel_valid;
      logic [PID_W-1:0]  sel_pid;
      logic [TIME_W-1:0] sel_remaining;
      route_type         route;
      logic              overflow;
   } result_type;

endpackage

// ===== src/longest_job_first_select_top.sv =====
// Longest-job-first select: ready table of up to TABLE_DEPTH (pid, remaining
// time) entries held in one single-port-read memory. An insert word appends
// its entry if the table has room; a schedule word that leaves the table
// empty goes straight to the result. Any other schedule word makes one pass
// over the table to find the longest job, then moves each later entry down
// one slot to close the gap, both limited by the table's one read port. The
// result sits in an output register so a new word can be taken while the
// last result waits on rsp_ready.
// Depends on ljfs_pkg, ljfs_table and ljfs_ctrl.
module longest_job_first_select_top
   import ljfs_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic        req_has_current,
   input  logic [15:0] req_current_pid,
   input  logic [1:0]  req_current_state,
   input  logic [15:0] req_current_remaining,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_selected_valid,
   output logic [15:0] rsp_selected_pid,
   output logic [15:0] rsp_selected_remaining,
   output logic [2:0]  rsp_route,
   output logic        rsp_overflow
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   entry_type     mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;
   entry_type     mem_rdata;
   logic          res_valid;
   result_type    res_data;
   logic          res_take;

   logic          rsp_valid_ff, rsp_valid_in;
   result_type    rsp_data_ff;

   ljfs_table #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   ljfs_ctrl #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_ctrl (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_mode              (req_mode),
      .req_has_current       (req_has_current),
      .req_current_pid       (req_current_pid),
      .req_current_state     (req_current_state),
      .req_current_remaining (req_current_remaining),
      .mem_we                (mem_we),
      .mem_waddr             (mem_waddr),
      .mem_wdata             (mem_wdata),
      .mem_re                (mem_re),
      .mem_raddr             (mem_raddr),
      .mem_rdata             (mem_rdata),
      .res_valid             (res_valid),
      .res_data              (res_data),
      .res_take              (res_take)
   );

   // output word register: load when empty or being drained
   assign res_take     = res_valid & (~rsp_valid_ff | rsp_ready);
   assign rsp_valid_in = res_take | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_selected_valid     = rsp_data_ff.sel_valid;
   assign rsp_selected_pid       = rsp_data_ff.sel_pid;
   assign rsp_selected_remaining = rsp_data_ff.sel_remaining;
   assign rsp_route              = rsp_data_ff.route;
   assign rsp_overflow           = rsp_data_ff.overflow;

endmodule

// ===== src/ljfs_table.sv =====
// Ready table storage: one write port, one read port, registered read data.
// Depends on ljfs_pkg for the entry layout.
module ljfs_table
   import ljfs_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  logic      clock,
   input  logic      we,
   input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] waddr,
   input  entry_type wdata,
   input  logic      re,
   input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] raddr,
   output entry_type rdata
);

   entry_type mem [TABLE_DEPTH];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/ljfs_ctrl.sv =====
// Sequencer: append on accept if wanted and not full; schedule words scan
// for the longest job, then move later entries down a slot. Uses ljfs_pkg.
module ljfs_ctrl
   import ljfs_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_mode,
   input  logic              req_has_current,
   input  logic [PID_W-1:0]  req_current_pid,
   input  logic [1:0]        req_current_state,
   input  logic [TIME_W-1:0] req_current_remaining,
   output logic              mem_we,
   output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] mem_waddr,
   output entry_type         mem_wdata,
   output logic              mem_re,
   output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] mem_raddr,
   input  entry_type         mem_rdata,
   output logic              res_valid,
   output result_type        res_data,
   input  logic              res_take
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_SHIFT  = 4'b0100,
      ST_RESULT = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     iss_ff, iss_in;      // next index to read
   logic              dv_ff, dv_in;        // read data valid this cycle
   logic [CW-1:0]     did_ff, did_in;      // index of read data
   logic [CW-1:0]     best_idx_ff, best_idx_in;
   logic [TIME_W-1:0] best_time_ff, best_time_in;
   logic [PID_W-1:0]  best_pid_ff, best_pid_in;
   result_type        res_ff, res_in;

   logic              full;
   logic              want_append;
   logic              append_ok;
   logic [CW-1:0]     count_after;
   logic [CW-1:0]     last;
   logic [CW-1:0]     did_prev;
   logic              take_new;
   logic [CW-1:0]     best_idx_n;
   logic [TIME_W-1:0] best_time_n;
   logic [PID_W-1:0]  best_pid_n;
   route_type         route_n;

   assign full        = (count_ff == CW'(TABLE_DEPTH));
   assign want_append = req_mode |
                        (req_has_current & (req_current_state == PSTATE_READY));
   assign append_ok   = want_append & ~full;
   assign count_after = count_ff + CW'(append_ok);
   assign last        = count_ff - CW'(1);
   assign did_prev    = did_ff - CW'(1);

   // running maximum; strict compare keeps the earliest entry on ties
   assign take_new    = dv_ff & ((did_ff == '0) | (mem_rdata.rtime > best_time_ff));
   assign best_idx_n  = take_new ? did_ff : best_idx_ff;
   assign best_time_n = take_new ? mem_rdata.rtime : best_time_ff;
   assign best_pid_n  = take_new ? mem_rdata.pid : best_pid_ff;

   always_comb begin
      route_n = ROUTE_NONE;
      if (req_has_current) begin
         case (req_current_state)
            PSTATE_READY:    route_n = ROUTE_READY;
            PSTATE_BLOCKED:  route_n = ROUTE_BLOCKED;
            PSTATE_FINISHED: route_n = ROUTE_FINISHED;
            default:         route_n = ROUTE_INVALID;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      iss_in       = iss_ff;
      dv_in        = 1'b0;
      did_in       = did_ff;
      best_idx_in  = best_idx_ff;
      best_time_in = best_time_ff;
      best_pid_in  = best_pid_ff;
      res_in       = res_ff;
      mem_we       = 1'b0;
      mem_waddr    = count_ff[AW-1:0];
      mem_wdata    = '{pid: req_current_pid, rtime: req_current_remaining};
      mem_re       = 1'b0;
      mem_raddr    = iss_ff[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (append_ok) begin
                  mem_we   = 1'b1;
                  count_in = count_after;
               end
               res_in.sel_valid     = 1'b0;
               res_in.sel_pid       = '0;
               res_in.sel_remaining = '0;
               res_in.route         = req_mode ? ROUTE_NONE : route_n;
               res_in.overflow      = want_append & full;
               iss_in               = '0;
               if (req_mode || (count_after == '0)) begin
                  state_in = ST_RESULT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (iss_ff != count_ff) begin
               mem_re = 1'b1;
               iss_in = iss_ff + CW'(1);
               dv_in  = 1'b1;
               did_in = iss_ff;
            end
            if (dv_ff) begin
               best_idx_in  = best_idx_n;
               best_time_in = best_time_n;
               best_pid_in  = best_pid_n;
            end
            if (dv_ff && (did_ff == last)) begin
               res_in.sel_valid     = 1'b1;
               res_in.sel_pid       = best_pid_n;
               res_in.sel_remaining = best_time_n;
               dv_in                = 1'b0;
               if (best_idx_n == last) begin
                  count_in = last;
                  state_in = ST_RESULT;
               end else begin
                  iss_in   = best_idx_n + CW'(1);
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            if (iss_ff != count_ff) begin
               mem_re = 1'b1;
               iss_in = iss_ff + CW'(1);
               dv_in  = 1'b1;
               did_in = iss_ff;
            end
            if (dv_ff) begin
               mem_we    = 1'b1;
               mem_waddr = did_prev[AW-1:0];
               mem_wdata = mem_rdata;
            end
            if (dv_ff && (did_ff == last)) begin
               dv_in    = 1'b0;
               count_in = last;
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         dv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         dv_ff    <= dv_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_ff       <= iss_in;
      did_ff       <= did_in;
      best_idx_ff  <= best_idx_in;
      best_time_ff <= best_time_in;
      best_pid_ff  <= best_pid_in;
      res_ff       <= res_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_RESULT);
   assign res_data  = res_ff;

endmodule
